[rtl/pvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types and constants for the pileup vote variant caller: command and
// operation codes, call kinds, counter slot layout and stream widths.
// ----------------------------------------------------------------------------
package pvc_pkg;

  // default sizing
  localparam int PVC_GENOME_POSITIONS = 65536;
  localparam int PVC_COUNT_BITS       = 16;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // width of a vote address before the range check (cursor plus offset)
  localparam int ADDR_CALC_W = 18;

  // counter slots in one table entry
  localparam int SLOTS = 14;
  localparam logic [3:0] SLOT_NONE     = 4'd0;
  localparam logic [3:0] SLOT_SUB      = 4'd1;
  localparam logic [3:0] SLOT_INS      = 4'd2;
  localparam logic [3:0] SLOT_DEL      = 4'd3;
  localparam logic [3:0] SLOT_SUB_BASE = 4'd4;
  localparam logic [3:0] SLOT_INS_BASE = 4'd9;

  // base code meaning no base
  localparam logic [2:0] BASE_ABSENT = 3'd5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ELEM  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_MATCH = 2'd0,
    OP_INS   = 2'd1,
    OP_DEL   = 2'd2,
    OP_OTHER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_INS  = 2'd2,
    KIND_DEL  = 2'd3
  } kind_e;

  // one input transaction, unpacked
  typedef struct packed {
    cmd_e        cmd;
    logic [16:0] position;
    op_e         op;
    logic        op_start;
    logic [2:0]  read_base;
    logic [2:0]  ref_base;
  } item_t;

  // vote or query address handed from the cursor to the sequencer
  typedef struct packed {
    logic [ADDR_CALC_W-1:0] addr;
    logic                   in_range;
  } addr_t;

endpackage

[rtl/pileup_vote_variant_caller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_vote_variant_caller
// Pileup majority vote caller: saturating vote counters per reference
// position in one memory, updated by aligned elements and read by queries.
//
//   channel  dir  tuser        tdata
//   in_      in   cmd          position, op, op_start, read_base, ref_base
//   out_     out  call_kind    call_base, call_position
//
// After reset a clearing pass writes every table entry to zero, one entry a
// cycle; no transaction is taken meanwhile.
// A start read, an ignored command or an element whose vote is not cast or
// falls past the table end only passes the check state; a voting element
// reads, updates (twice when it also counts a base) and writes back one entry
// through the one vote memory and the shared counter unit.
// A query reads its entry (no read past the table end), then compares the
// kind counters and, for a substitution or insertion, the base counters,
// one counter compare a cycle, and waits for the output register to be taken.
// ----------------------------------------------------------------------------
module pileup_vote_variant_caller import pvc_pkg::*; #(
  parameter int GENOME_POSITIONS = PVC_GENOME_POSITIONS,
  parameter int COUNT_BITS       = PVC_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [16:0] position, [18:17] op, [19] op_start, [22:20] read_base,
  // [25:23] ref_base, [31:26] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] call_base, [18:3] call_position, [23:19] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] call_kind
  output logic [1:0]             out_tuser
);

  localparam int AW = $clog2(GENOME_POSITIONS);

  typedef logic [SLOTS-1:0][COUNT_BITS-1:0] entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_INC,
    S_WRITE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e          state_r;
  logic [AW-1:0]   clr_idx_r;
  item_t           item;
  logic            accept;
  addr_t           vote_addr;
  logic [AW-1:0]   mem_addr;

  // vote plan of the current element
  logic            vote_r, has2_r;
  logic [3:0]      slot_r, slot2_r;
  logic            plan_vote, plan_has2;
  logic [3:0]      plan_slot, plan_slot2;
  logic            rd_ok, rf_ok;
  cmd_e            cmd_r;
  logic [15:0]     qpos_r;

  // entry under work
  entry_t          vote_mem [GENOME_POSITIONS];
  entry_t          rdata_r;
  entry_t          entry_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  // scan state
  logic                  phase_base_r;
  logic [2:0]            scan_i_r;
  logic [2:0]            win_r;
  logic [COUNT_BITS-1:0] top_r;
  logic [3:0]            base_first_r;
  kind_e                 kind_r;
  logic [2:0]            scan_last;
  logic [2:0]            win_now;
  logic [3:0]            unit_slot;
  kind_e                 kind_now;

  // shared unit ports
  logic [COUNT_BITS-1:0] cnt_a;
  logic [COUNT_BITS-1:0] sat_inc;
  logic                  a_gt_b;

  // result staging and output register
  kind_e           res_kind_r;
  logic [2:0]      res_base_r;
  logic            out_valid_r;
  kind_e           out_kind_r;
  logic [2:0]      out_base_r;
  logic [15:0]     out_pos_r;

  // input unpacking
  always_comb begin
    item.cmd       = cmd_e'(in_tuser);
    item.position  = in_tdata[16:0];
    item.op        = op_e'(in_tdata[18:17]);
    item.op_start  = in_tdata[19];
    item.read_base = in_tdata[22:20];
    item.ref_base  = in_tdata[25:23];
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  pvc_cursor #(
    .GENOME_POSITIONS(GENOME_POSITIONS)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .vote_addr(vote_addr)
  );

  assign mem_addr = AW'(vote_addr.addr);

  // vote plan decode; codes six and seven count as absent
  assign rd_ok = item.read_base < BASE_ABSENT;
  assign rf_ok = item.ref_base < BASE_ABSENT;

  always_comb begin
    plan_vote  = (item.cmd == CMD_ELEM);
    plan_has2  = 1'b0;
    plan_slot  = SLOT_NONE;
    plan_slot2 = SLOT_SUB_BASE + {1'b0, item.read_base};
    unique case (item.op)
      OP_MATCH: begin
        if (rd_ok && rf_ok && item.read_base == item.ref_base) begin
          plan_slot = SLOT_NONE;
        end else begin
          plan_slot = SLOT_SUB;
          plan_has2 = rd_ok;
        end
      end
      OP_INS: begin
        plan_slot  = SLOT_INS;
        plan_has2  = rd_ok;
        plan_slot2 = SLOT_INS_BASE + {1'b0, item.read_base};
      end
      OP_DEL: begin
        plan_slot = SLOT_DEL;
      end
      OP_OTHER: begin
        plan_vote = 1'b0;
      end
      default: begin
        plan_vote = 1'b0;
      end
    endcase
  end

  // shared unit operand selection
  assign scan_last = phase_base_r ? 3'd4 : 3'd3;

  always_comb begin
    if (state_r == S_INC) begin
      unit_slot = slot_r;
    end else if (phase_base_r) begin
      unit_slot = base_first_r + {1'b0, scan_i_r};
    end else begin
      unit_slot = {1'b0, scan_i_r};
    end
  end

  assign cnt_a    = entry_r[unit_slot];
  assign win_now  = a_gt_b ? scan_i_r : win_r;
  assign kind_now = kind_e'(win_now[1:0]);

  pvc_count_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_count (
    .cnt_a  (cnt_a),
    .cnt_b  (top_r),
    .sat_inc(sat_inc),
    .a_gt_b (a_gt_b)
  );

  // memory port: clearing pass or write back
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_idx_r : mem_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : entry_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vote_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= vote_mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + {{(AW-1){1'b0}}, 1'b1};
          if (clr_idx_r == AW'(GENOME_POSITIONS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= item.cmd;
            qpos_r  <= item.position[15:0];
            vote_r  <= plan_vote;
            has2_r  <= plan_has2;
            slot_r  <= plan_slot;
            slot2_r <= plan_slot2;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          phase_base_r <= 1'b0;
          scan_i_r     <= '0;
          win_r        <= '0;
          top_r        <= '0;
          if (cmd_r == CMD_QUERY) begin
            if (vote_addr.in_range) begin
              state_r <= S_READ;
            end else begin
              entry_r <= '0;
              state_r <= S_SCAN;
            end
          end else if (vote_r && vote_addr.in_range) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          entry_r <= rdata_r;
          state_r <= (cmd_r == CMD_QUERY) ? S_SCAN : S_INC;
        end
        S_INC: begin
          entry_r[slot_r] <= sat_inc;
          if (has2_r) begin
            slot_r <= slot2_r;
            has2_r <= 1'b0;
          end else begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_i_r != scan_last) begin
            if (a_gt_b) begin
              top_r <= cnt_a;
            end
            win_r    <= win_now;
            scan_i_r <= scan_i_r + 3'd1;
          end else if (!phase_base_r) begin
            // kind decided; substitution and insertion go on to a base search
            kind_r <= kind_now;
            if (kind_now == KIND_SUB || kind_now == KIND_INS) begin
              phase_base_r <= 1'b1;
              base_first_r <= (kind_now == KIND_SUB) ? SLOT_SUB_BASE : SLOT_INS_BASE;
              scan_i_r     <= '0;
              win_r        <= BASE_ABSENT;
              top_r        <= '0;
            end else begin
              res_kind_r <= kind_now;
              res_base_r <= (kind_now == KIND_DEL) ? BASE_ABSENT : 3'd0;
              state_r    <= S_DONE;
            end
          end else begin
            // no base counted means no call
            if (win_now == BASE_ABSENT) begin
              res_kind_r <= KIND_NONE;
              res_base_r <= 3'd0;
            end else begin
              res_kind_r <= kind_r;
              res_base_r <= win_now;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_base_r  <= res_base_r;
            out_pos_r   <= qpos_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // output channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_pos_r, out_base_r};

`ifndef SYNTHESIS
  // a deletion call always carries the deletion marker
  a_del_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DEL) |-> (out_tdata[2:0] == BASE_ABSENT))
    else $error("deletion call without deletion marker");

  // no call reports base zero
  a_none_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_NONE) |-> (out_tdata[2:0] == 3'd0))
    else $error("no call with non-zero base");

  // substitution and insertion calls name a real base
  a_real_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_SUB || out_tuser == KIND_INS))
      |-> (out_tdata[2:0] < BASE_ABSENT))
    else $error("substitution or insertion call without a base");

  // write back only to an address inside the table
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (vote_addr.in_range && vote_r && cmd_r == CMD_ELEM))
    else $error("write back outside the table or without a vote");
`endif

endmodule

[rtl/pvc_count_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_count_unit
// Shared counter arithmetic: saturating increment of one counter and a
// strict greater-than compare against the running best.
// ----------------------------------------------------------------------------
module pvc_count_unit import pvc_pkg::*; #(
  parameter int COUNT_BITS = PVC_COUNT_BITS
) (
  input  logic [COUNT_BITS-1:0] cnt_a,
  input  logic [COUNT_BITS-1:0] cnt_b,
  output logic [COUNT_BITS-1:0] sat_inc,
  output logic                  a_gt_b
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // counter stops at its maximum
  assign sat_inc = (cnt_a == CountMax) ? cnt_a : cnt_a + {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // strict compare keeps the earliest maximum
  assign a_gt_b = cnt_a > cnt_b;

endmodule

[rtl/pvc_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_cursor
// Reference cursor and insertion offset; registers the table address of each
// accepted element or query together with its range check.
// ----------------------------------------------------------------------------
module pvc_cursor import pvc_pkg::*; #(
  parameter int GENOME_POSITIONS = PVC_GENOME_POSITIONS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  item_t item,
  output addr_t vote_addr
);

  localparam logic [31:0] GenomeLimit = 32'(GENOME_POSITIONS);

  logic [16:0]            cursor_r;
  logic [15:0]            off_r;
  logic [15:0]            off_eff;
  logic [ADDR_CALC_W-1:0] ins_sum;
  logic [ADDR_CALC_W-1:0] addr_nxt;
  addr_t                  addr_r;

  // offset restarts on the first element of an operation
  assign off_eff = item.op_start ? 16'd0 : off_r;
  assign ins_sum = {1'b0, cursor_r} + {2'b00, off_eff};

  // address used by this transaction
  always_comb begin
    addr_nxt = {1'b0, cursor_r};
    if (item.cmd == CMD_QUERY) begin
      addr_nxt = {1'b0, item.position};
    end else if (item.op == OP_INS) begin
      addr_nxt = ins_sum;
    end
  end

  // cursor and offset update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      off_r    <= '0;
    end else if (accept) begin
      if (item.cmd == CMD_START) begin
        cursor_r <= item.position - 17'd1;
        off_r    <= '0;
      end else if (item.cmd == CMD_ELEM) begin
        off_r <= off_eff + 16'd1;
        if (item.op == OP_MATCH || item.op == OP_DEL) begin
          cursor_r <= cursor_r + 17'd1;
        end
      end
    end
  end

  // registered address and range check
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r.addr     <= addr_nxt;
      addr_r.in_range <= 32'(addr_nxt) < GenomeLimit;
    end
  end

  assign vote_addr = addr_r;

endmodule
